/* rtl/core/dpl_pkg.sv */
// Shared types and constants for the decimal program loader.
// Used by dpl_front, dpl_queue, dpl_back and decimal_program_loader.
package dpl_pkg;

    // Event queue depth between the front and back parts
    localparam int DPL_QUEUE_DEPTH = 4;

    // Status codes carried in status results
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_TOO_MANY = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    // Result kinds
    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // One input transaction
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_file;
    } t_in_item;

    // One output transaction
    typedef struct packed {
        logic               kind;
        logic [30:0]        word_index;
        logic signed [31:0] word_value;
        logic [2:0]         status_code;
        logic [30:0]        word_count;
        logic               last;
    } t_out_item;

    // Event handed from the front to the back
    typedef struct packed {
        logic        is_ovf;     // overflow, halt
        logic        is_final;   // end of file
        logic        has_value;  // a line value is taken
        logic [31:0] value;      // two's complement value
    } t_event;

endpackage

/* rtl/core/dpl_front.sv */
// Front part: lexes the byte stream line by line and pushes value,
// end-of-file and overflow events. Depends on dpl_pkg.
module dpl_front
    import dpl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in,
    input  logic     i_q_full,
    output logic     o_push,
    output t_event   o_event
);

    // Line phases
    localparam logic [2:0] PH_BLANKS  = 3'd0;
    localparam logic [2:0] PH_MINUS   = 3'd1;
    localparam logic [2:0] PH_DIGITS  = 3'd2;
    localparam logic [2:0] PH_TAIL    = 3'd3;
    localparam logic [2:0] PH_INVALID = 3'd4;

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam logic [35:0] POS_LIMIT = 36'd2147483647;
    localparam logic [35:0] NEG_LIMIT = 36'd2147483648;

    logic [2:0]  r_phase, n_phase;
    logic        r_neg, n_neg;
    logic [31:0] r_mag, n_mag;
    logic        r_halted, n_halted;

    logic        accept;
    logic        is_digit, is_blank, pending;
    logic [3:0]  digit;
    logic [35:0] acc;
    logic [31:0] value;

    // Halted input is drained without effect
    assign o_in_ready = r_halted | ~i_q_full;
    assign accept     = i_in_valid & o_in_ready & ~r_halted;

    assign is_digit = (i_in.char_in >= CH_ZERO) && (i_in.char_in <= CH_NINE);
    assign is_blank = (i_in.char_in == CH_SPACE) || (i_in.char_in == CH_TAB);
    assign digit    = 4'(i_in.char_in - CH_ZERO);
    assign pending  = (r_phase == PH_DIGITS) || (r_phase == PH_TAIL);

    // Multiply-by-ten accumulate
    assign acc   = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0} + {32'd0, digit};
    assign value = r_neg ? (32'd0 - r_mag) : r_mag;

    // Line parser
    always_comb begin
        n_phase  = r_phase;
        n_neg    = r_neg;
        n_mag    = r_mag;
        n_halted = r_halted;
        o_push   = 1'b0;
        o_event  = '{is_ovf: 1'b0, is_final: 1'b0, has_value: pending, value: value};
        if (accept) begin
            if (i_in.end_of_file) begin
                o_push           = 1'b1;
                o_event.is_final = 1'b1;
                n_phase          = PH_BLANKS;
                n_neg            = 1'b0;
                n_halted         = 1'b1;
            end else if (i_in.char_in == CH_NL) begin
                o_push  = pending;
                n_phase = PH_BLANKS;
                n_neg   = 1'b0;
            end else begin
                unique case (r_phase)
                    PH_BLANKS: begin
                        if (is_digit) begin
                            n_phase = PH_DIGITS;
                            n_neg   = 1'b0;
                            n_mag   = {28'd0, digit};
                        end else if (i_in.char_in == CH_MINUS) begin
                            n_phase = PH_MINUS;
                        end else if (!is_blank) begin
                            n_phase = PH_INVALID;
                        end
                    end
                    PH_MINUS: begin
                        if (is_digit) begin
                            n_phase = PH_DIGITS;
                            n_neg   = 1'b1;
                            n_mag   = {28'd0, digit};
                        end else begin
                            n_phase = PH_INVALID;
                        end
                    end
                    PH_DIGITS: begin
                        if (is_digit) begin
                            if (acc > (r_neg ? NEG_LIMIT : POS_LIMIT)) begin
                                o_push            = 1'b1;
                                o_event.is_ovf    = 1'b1;
                                o_event.has_value = 1'b0;
                                n_phase           = PH_BLANKS;
                                n_neg             = 1'b0;
                                n_halted          = 1'b1;
                            end else begin
                                n_mag = acc[31:0];
                            end
                        end else begin
                            n_phase = PH_TAIL;
                        end
                    end
                    PH_TAIL: begin
                        n_phase = PH_TAIL;
                    end
                    default: begin
                        n_phase = PH_INVALID;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_BLANKS;
            r_neg    <= 1'b0;
            r_halted <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_neg    <= n_neg;
            r_halted <= n_halted;
        end
        r_mag <= n_mag;
    end

`ifndef NO_ASSERTIONS
    // Once halted, only reset releases the front
    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted) else $error("front left halt");
`endif

endmodule

/* rtl/core/dpl_queue.sv */
// Short event queue between the front and back parts.
// Depends on dpl_pkg for the event type.
module dpl_queue
    import dpl_pkg::*;
#(
    parameter int DEPTH = DPL_QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_event,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_event o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_event           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_event;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue overrun");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue underrun");
`endif

endmodule

/* rtl/core/dpl_back.sv */
// Back part: applies header and word-count bookkeeping to queued events
// and drives the registered result channel. Depends on dpl_pkg.
module dpl_back
    import dpl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_event    i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    logic        r_hdr, n_hdr;
    logic [31:0] r_dc, n_dc;
    logic [31:0] r_ls, n_ls;
    logic        r_sub, n_sub;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    logic        can_emit, tv_emit, emit;
    t_out_item   res;
    t_out_item   word_res, stat_res;

    assign can_emit = ~r_out_valid | i_out_ready;
    assign tv_emit  = r_hdr & ~r_dc[31] & (r_ls < r_dc);

    // Word result for the value at the queue head
    always_comb begin
        word_res             = '0;
        word_res.kind        = KIND_WORD;
        word_res.word_index  = r_ls[30:0];
        word_res.word_value  = $signed(i_head.value);
    end

    // Final status from current bookkeeping
    always_comb begin
        stat_res      = '0;
        stat_res.kind = KIND_STATUS;
        stat_res.last = 1'b1;
        if (i_head.is_ovf) begin
            stat_res.status_code = ST_OVERFLOW;
        end else if (!r_hdr) begin
            stat_res.status_code = ST_EMPTY;
        end else if (r_dc[31] || (r_ls > r_dc)) begin
            stat_res.status_code = ST_TOO_MANY;
        end else if (r_ls < r_dc) begin
            stat_res.status_code = ST_SHORT;
            stat_res.word_count  = r_ls[30:0];
        end else begin
            stat_res.status_code = ST_OK;
            stat_res.word_count  = r_dc[30:0];
        end
    end

    // Event execution
    always_comb begin
        n_hdr = r_hdr;
        n_dc  = r_dc;
        n_ls  = r_ls;
        n_sub = r_sub;
        o_pop = 1'b0;
        emit  = 1'b0;
        res   = stat_res;
        if (i_q_valid) begin
            if (i_head.is_ovf || (i_head.is_final && (r_sub || !i_head.has_value))) begin
                // status result ends this transaction
                if (can_emit) begin
                    emit  = 1'b1;
                    o_pop = 1'b1;
                    n_sub = 1'b0;
                end
            end else if (!tv_emit || can_emit) begin
                // take a line value
                res      = word_res;
                res.last = ~i_head.is_final;
                emit     = tv_emit;
                if (!r_hdr) begin
                    if (i_head.value != '0) begin
                        n_dc  = i_head.value;
                        n_hdr = 1'b1;
                    end
                end else if (r_ls != '1) begin
                    n_ls = r_ls + 1'b1;
                end
                if (i_head.is_final) begin
                    n_sub = 1'b1;
                end else begin
                    o_pop = 1'b1;
                end
            end
        end
    end

    // Output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr       <= 1'b0;
            r_dc        <= '0;
            r_ls        <= '0;
            r_sub       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_hdr       <= n_hdr;
            r_dc        <= n_dc;
            r_ls        <= n_ls;
            r_sub       <= n_sub;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef NO_ASSERTIONS
    // Second step of an end-of-file event only while that event is at the head
    a_sub_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (i_q_valid && i_head.is_final)) else $error("stray second step");
    // Words only go out under a valid nonnegative header
    a_word_has_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind == KIND_WORD)) |-> (r_hdr && !r_dc[31]))
        else $error("word without header");
    // Header once taken is never dropped
    a_hdr_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr |=> (r_hdr && $stable(r_dc))) else $error("header changed");
`endif

endmodule

/* rtl/core/decimal_program_loader.sv */
// Top level of the decimal program loader: front lexer, event queue, back.
// Depends on dpl_pkg, dpl_front, dpl_queue and dpl_back.
//
//  channel  | signals                            | payload
//  ---------+------------------------------------+------------
//  input    | i_in_valid / o_in_ready            | i_in  (t_in_item)
//  output   | o_out_valid / i_out_ready          | o_out (t_out_item)
//
// One byte is taken per cycle while the event queue is not full; the front lexer
// and its multiply-by-ten accumulate finish a byte in the cycle it is accepted.
// A line value passes from the front through the event queue to the back's output
// register; an end of file with a pending value is taken as a value step, then a status step.
// The input stalls only when the event queue is full; results wait in the
// output register while the back keeps draining line values that make no word.
// Synchronous active-low reset clears all control state; no clearing pass.
module decimal_program_loader
    import dpl_pkg::*;
#(
    parameter int QUEUE_DEPTH = DPL_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    logic   q_full, q_valid, push, pop;
    t_event push_event, head;

    dpl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_event    (push_event)
    );

    dpl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_event (push_event),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    dpl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

/* tb/sv/tb_decimal_program_loader.sv */
`timescale 1ns / 1ps
// Self-checking testbench for decimal_program_loader: streams one program text
// byte by byte and checks every word and status against a built-in lexer.
// Depends on dpl_pkg and the decimal_program_loader RTL.
module tb_decimal_program_loader;
    import dpl_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int BODY_BYTES     = 520;
    localparam int MAX_REPORTS    = 10;
    localparam int NO_LEAD        = -1;
    localparam int IDLE_PHASES    = 5;

    // Byte codes the lexer cares about
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam logic [63:0] INT_MAX_MAG = 64'h7FFF_FFFF;
    localparam logic [63:0] INT_MIN_MAG = 64'h8000_0000;

    typedef enum logic [2:0] {
        LP_BLANKS, LP_MINUS, LP_DIGITS, LP_TAIL, LP_INVALID
    } t_line_phase;

    typedef enum int {ROW_QUIET, ROW_HEADER, ROW_CHECKED} t_row_role;
    typedef enum int {
        END_AFTER_NL, END_PENDING_VALUE, END_PENDING_MINUS, END_OVERFLOW
    } t_ending;

    // One line of the directed table; quiet rows must cause no result
    typedef struct {
        t_row_role role;
        int        lead;
        string     text;
        bit        holds_value;
    } t_line_row;

    typedef struct packed {
        t_in_item item;
        logic     quiet;
    } t_text_byte;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    always #5 clk = ~clk;

    decimal_program_loader i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    // Lexer state mirrored from the block
    t_line_phase lx_phase;
    logic        lx_negative;
    logic [31:0] lx_magnitude;
    logic        hdr_taken;
    logic [31:0] hdr_count;
    logic [31:0] values_taken;
    logic        lx_halted;

    t_out_item   step_records[$];
    t_out_item   pending_records[$];
    t_text_byte  program_text[$];

    int planned_values = 0;
    int idle_phase     = 0;
    int accepted_bytes = 0;
    int fault_count    = 0;
    int idle_cycles    = 0;

    function automatic void start_line();
        lx_phase     = LP_BLANKS;
        lx_negative  = 1'b0;
        lx_magnitude = '0;
    endfunction

    function automatic void post_record(logic kind, logic [30:0] index, logic [31:0] value,
                                        logic [2:0] code, logic [30:0] count);
        t_out_item rec;
        rec.kind        = kind;
        rec.word_index  = index;
        rec.word_value  = value;
        rec.status_code = code;
        rec.word_count  = count;
        rec.last        = 1'b0;
        step_records.push_back(rec);
    endfunction

    // First nonzero value is the count; later values are words while they fit
    function automatic void take_line_value();
        logic [31:0] value;
        value = lx_negative ? -lx_magnitude : lx_magnitude;
        if (!hdr_taken) begin
            if (value != '0) begin
                hdr_count = value;
                hdr_taken = 1'b1;
            end
        end else begin
            if (!hdr_count[31] && values_taken < hdr_count)
                post_record(KIND_WORD, values_taken[30:0], value, ST_OK, '0);
            if (values_taken != '1)
                values_taken++;
        end
    endfunction

    function automatic void close_program();
        if (!hdr_taken)
            post_record(KIND_STATUS, '0, '0, ST_EMPTY, '0);
        else if (hdr_count[31] || values_taken > hdr_count)
            post_record(KIND_STATUS, '0, '0, ST_TOO_MANY, '0);
        else if (values_taken < hdr_count)
            post_record(KIND_STATUS, '0, '0, ST_SHORT, values_taken[30:0]);
        else
            post_record(KIND_STATUS, '0, '0, ST_OK, hdr_count[30:0]);
    endfunction

    // Advance the lexer by one byte; results land in step_records
    function automatic void lex_byte(t_in_item it);
        logic [7:0]  c;
        logic        is_digit;
        logic        is_blank;
        logic [63:0] grown;
        logic [63:0] limit;
        c        = it.char_in;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        is_blank = (c == CH_SPACE) || (c == CH_TAB);
        step_records.delete();
        if (lx_halted)
            return;
        if (it.end_of_file) begin
            if (lx_phase == LP_DIGITS || lx_phase == LP_TAIL)
                take_line_value();
            start_line();
            close_program();
            lx_halted = 1'b1;
        end else if (c == CH_NL) begin
            if (lx_phase == LP_DIGITS || lx_phase == LP_TAIL)
                take_line_value();
            start_line();
        end else begin
            case (lx_phase)
                LP_BLANKS: begin
                    if (is_digit) begin
                        lx_phase     = LP_DIGITS;
                        lx_negative  = 1'b0;
                        lx_magnitude = 32'(c - CH_ZERO);
                    end else if (c == CH_MINUS) begin
                        lx_phase = LP_MINUS;
                    end else if (!is_blank) begin
                        lx_phase = LP_INVALID;
                    end
                end
                LP_MINUS: begin
                    if (is_digit) begin
                        lx_phase     = LP_DIGITS;
                        lx_negative  = 1'b1;
                        lx_magnitude = 32'(c - CH_ZERO);
                    end else begin
                        lx_phase = LP_INVALID;
                    end
                end
                LP_DIGITS: begin
                    if (is_digit) begin
                        grown = {32'b0, lx_magnitude} * 64'd10 + 64'(c - CH_ZERO);
                        limit = lx_negative ? INT_MIN_MAG : INT_MAX_MAG;
                        if (grown > limit) begin
                            post_record(KIND_STATUS, '0, '0, ST_OVERFLOW, '0);
                            start_line();
                            lx_halted = 1'b1;
                        end else begin
                            lx_magnitude = grown[31:0];
                        end
                    end else begin
                        lx_phase = LP_TAIL;
                    end
                end
                LP_TAIL: begin
                end
                default: begin
                    lx_phase = LP_INVALID;
                end
            endcase
        end
    endfunction

    function automatic string record_text(t_out_item r);
        return $sformatf("kind=%0d index=%0d value=%0d code=%0d count=%0d last=%0d",
                         r.kind, r.word_index, r.word_value, r.status_code,
                         r.word_count, r.last);
    endfunction

    // Compare one output transaction with the oldest expectation
    function automatic void check_record(t_out_item got);
        t_out_item want;
        if (pending_records.size() == 0) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
                $display("unexpected result: %s", record_text(got));
            return;
        end
        want = pending_records.pop_front();
        if (got.kind !== want.kind || got.word_index !== want.word_index
                || got.word_value !== want.word_value
                || got.status_code !== want.status_code
                || got.word_count !== want.word_count || got.last !== want.last) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
                $display("mismatch: expected %s, got %s", record_text(want), record_text(got));
        end
    endfunction

    function automatic int idle_pct(bit receiver, int phase);
        case (phase)
            1: return receiver ? 0 : 82;
            2: return receiver ? 82 : 0;
            3: return 33;
            default: return 0;
        endcase
    endfunction

    // Random byte other than newline, optionally also no digit / no blank or minus
    function automatic logic [7:0] random_byte(bit no_digit, bit no_blank);
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == CH_NL || (no_digit && c >= CH_ZERO && c <= CH_NINE)
                   || (no_blank && (c == CH_SPACE || c == CH_TAB || c == CH_MINUS)));
        return c;
    endfunction

    function automatic logic [7:0] random_blank();
        return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic void push_byte(logic [7:0] c, logic eof, logic quiet);
        t_text_byte b;
        b.item.char_in     = c;
        b.item.end_of_file = eof;
        b.quiet            = quiet;
        program_text.push_back(b);
    endfunction

    function automatic void push_text(string s, logic quiet);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], 1'b0, quiet);
    endfunction

    // Well-formed value line: blanks, sign, leading zeros, digits, optional tail
    task automatic add_value_line(input bit end_line);
        logic [63:0] mag;
        bit          neg;
        int          roll;
        int          zeros;
        repeat ($urandom_range(0, 3)) push_byte(random_blank(), 1'b0, 1'b0);
        neg  = $urandom_range(0, 1);
        roll = $urandom_range(0, 9);
        if (roll < 5)
            mag = $urandom_range(0, 999);
        else if (roll < 8)
            mag = {32'b0, $urandom()} & INT_MAX_MAG;
        else if (roll == 8)
            mag = neg ? INT_MIN_MAG : INT_MAX_MAG;
        else
            mag = INT_MAX_MAG - $urandom_range(0, 9);
        if (neg)
            push_byte(CH_MINUS, 1'b0, 1'b0);
        zeros = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 12);
        repeat (zeros) push_byte(CH_ZERO, 1'b0, 1'b0);
        push_text($sformatf("%0d", mag), 1'b0);
        if ($urandom_range(0, 2) == 0) begin
            push_byte(random_byte(1'b1, 1'b0), 1'b0, 1'b0);
            repeat ($urandom_range(0, 4)) push_byte(random_byte(1'b0, 1'b0), 1'b0, 1'b0);
        end
        if (end_line)
            push_byte(CH_NL, 1'b0, 1'b0);
        planned_values++;
    endtask

    // Present one input transaction and hold it until accepted
    task automatic send_item(input t_in_item item);
        while ($urandom_range(0, 99) < idle_pct(1'b0, idle_phase)) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver back-pressure
    always @(negedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= idle_pct(1'b1, idle_phase));
    end

    // Predict on accepted input, check accepted output, watch for a hang
    always @(posedge clk) begin : monitor
        logic in_fire;
        logic out_fire;
        in_fire  = in_valid && in_ready;
        out_fire = out_valid && out_ready;
        if (rst_n) begin
            if (in_fire) begin
                lex_byte(in_item);
                if (!program_text[accepted_bytes].quiet && step_records.size() > 0) begin
                    step_records[step_records.size() - 1].last = 1'b1;
                    foreach (step_records[k])
                        pending_records.push_back(step_records[k]);
                end
                accepted_bytes++;
            end
            if (out_fire)
                check_record(out_item);
            if (in_fire || out_fire) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("tb_decimal_program_loader: errors");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        t_line_row   directed_rows [19];
        t_text_byte  body_text[$];
        t_ending     ending;
        logic [63:0] mag;
        logic [63:0] limit;
        bit          neg;
        bit          quiet;
        int          roll;
        int          hdr_value;
        string       hdr_text;

        directed_rows = '{
            '{ROW_QUIET,   NO_LEAD, "\n",                          1'b0},  // empty line
            '{ROW_QUIET,   NO_LEAD, " \t  \t\n",                   1'b0},  // blanks only
            '{ROW_QUIET,   NO_LEAD, "0\n",                         1'b0},  // zero, no count yet
            '{ROW_QUIET,   NO_LEAD, "  -0000\n",                   1'b0},  // minus zero
            '{ROW_QUIET,   CH_CR,   "7\n",                         1'b0},  // CR before digit
            '{ROW_QUIET,   CH_NUL,  " 3\n",                        1'b0},  // NUL before digit
            '{ROW_QUIET,   NO_LEAD, "-x5\n",                       1'b0},
            '{ROW_QUIET,   NO_LEAD, "-\n",                         1'b0},
            '{ROW_HEADER,  NO_LEAD, "",                            1'b0},
            '{ROW_CHECKED, NO_LEAD, "2147483647\n",                1'b1},
            '{ROW_CHECKED, NO_LEAD, "-2147483648\n",               1'b1},
            '{ROW_CHECKED, NO_LEAD, "  -00042abc9\n",              1'b1},
            '{ROW_CHECKED, NO_LEAD, "\t000000000002147483647 x\n", 1'b1},  // zeros by value
            '{ROW_CHECKED, NO_LEAD, "5\377\n",                     1'b1},
            '{ROW_CHECKED, NO_LEAD, "12\015\n",                    1'b1},  // CR in tail
            '{ROW_CHECKED, NO_LEAD, "\t\t-0\n",                    1'b1},
            '{ROW_CHECKED, NO_LEAD, "- 4\n",                       1'b0},
            '{ROW_CHECKED, NO_LEAD, "x9\n",                        1'b0},
            '{ROW_CHECKED, NO_LEAD, "\n",                          1'b0}
        };

        lx_halted = 1'b0;
        start_line();
        hdr_taken    = 1'b0;
        hdr_count    = '0;
        values_taken = '0;

        foreach (directed_rows[r])
            if (directed_rows[r].holds_value)
                planned_values++;

        // Random body: mostly well-formed value lines, some broken ones
        while (program_text.size() < BODY_BYTES) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                add_value_line(1'b1);
            end else if (roll < 80) begin
                push_byte(random_byte(1'b1, 1'b1), 1'b0, 1'b0);
                repeat ($urandom_range(0, 5)) push_byte(random_byte(1'b0, 1'b0), 1'b0, 1'b0);
                push_byte(CH_NL, 1'b0, 1'b0);
            end else if (roll < 87) begin
                repeat ($urandom_range(1, 4)) push_byte(random_blank(), 1'b0, 1'b0);
                push_byte(CH_NL, 1'b0, 1'b0);
            end else if (roll < 93) begin
                push_byte(CH_NL, 1'b0, 1'b0);
            end else begin
                push_byte(CH_MINUS, 1'b0, 1'b0);
                push_byte(random_byte(1'b1, 1'b0), 1'b0, 1'b0);
                repeat ($urandom_range(0, 3)) push_byte(random_byte(1'b0, 1'b0), 1'b0, 1'b0);
                push_byte(CH_NL, 1'b0, 1'b0);
            end
        end

        // How the text ends
        ending = t_ending'($urandom_range(0, 3));
        case (ending)
            END_AFTER_NL: begin
                push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            end
            END_PENDING_VALUE: begin
                add_value_line(1'b0);
                push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            end
            END_PENDING_MINUS: begin
                push_byte(random_blank(), 1'b0, 1'b0);
                push_byte(CH_MINUS, 1'b0, 1'b0);
                push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            end
            default: begin
                neg   = $urandom_range(0, 1);
                limit = neg ? INT_MIN_MAG : INT_MAX_MAG;
                roll  = $urandom_range(0, 2);
                if (roll == 0)
                    mag = limit + 1;
                else if (roll == 1)
                    mag = limit + 1 + $urandom_range(0, 100000);
                else
                    mag = 64'd10_000_000_000 + $urandom();
                if (neg)
                    push_byte(CH_MINUS, 1'b0, 1'b0);
                repeat ($urandom_range(0, 3)) push_byte(CH_ZERO, 1'b0, 1'b0);
                push_text($sformatf("%0d", mag), 1'b0);
                push_text("x\n", 1'b0);
                push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            end
        endcase

        // Bytes after the halt must be ignored
        push_text(" 42\n", 1'b0);
        repeat (4) push_byte(random_byte(1'b0, 1'b0), 1'b0, 1'b0);
        push_byte(CH_NL, 1'b0, 1'b0);
        push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        push_text("7\n", 1'b0);

        // Declared count: exact, short, too many or negative, extremes included
        roll = $urandom_range(0, 99);
        if (roll < 30)
            hdr_value = planned_values;
        else if (roll < 35)
            hdr_value = 32'h7FFF_FFFF;
        else if (roll < 55)
            hdr_value = planned_values + $urandom_range(1, 50);
        else if (roll < 60)
            hdr_value = 1;
        else if (roll < 85)
            hdr_value = $urandom_range(planned_values / 2, planned_values - 1);
        else if (roll < 90)
            hdr_value = 32'h8000_0000;
        else
            hdr_value = -int'($urandom_range(1, 1000));
        hdr_text = $sformatf("%s%0d\n", ($urandom_range(0, 1) ? " \t" : ""), hdr_value);

        // Directed table goes in front of the random body
        body_text = program_text;
        program_text.delete();
        foreach (directed_rows[r]) begin
            quiet = (directed_rows[r].role != ROW_CHECKED);
            if (directed_rows[r].lead != NO_LEAD)
                push_byte(8'(directed_rows[r].lead), 1'b0, quiet);
            if (directed_rows[r].role == ROW_HEADER)
                push_text(hdr_text, 1'b1);
            else
                push_text(directed_rows[r].text, quiet);
        end
        program_text = {program_text, body_text};

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        foreach (program_text[i]) begin
            idle_phase = i * IDLE_PHASES / program_text.size();
            send_item(program_text[i].item);
        end
        in_valid   <= 1'b0;
        idle_phase = IDLE_PHASES - 1;

        // Drain, then give a stray result time to show up
        while (pending_records.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("tb_decimal_program_loader: clean");
        else
            $display("tb_decimal_program_loader: errors");
        $finish;
    end

endmodule
